### sv/ps2mp_pkg.sv
// Shared types, constants and helpers for the PS/2 mouse pointer block.
// No dependencies; used by ps2_mouse_packet_to_pointer.
package ps2mp_pkg;

  // Position register width; the position saturates at 2^POS_WIDTH-1.
  localparam int POS_WIDTH = 12;
  localparam int SIZE_W    = 13;   // columns / rows register width
  localparam int PTR_W     = 12;   // pointer fields in a result
  localparam int STEP_W    = ((POS_WIDTH > SIZE_W) ? POS_WIDTH : SIZE_W) + 2;
  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  // Motion arithmetic: accumulator + motion stays within +/-510.
  localparam int ACC_W     = 9;
  localparam int SUM_W     = 10;
  localparam int MAG_W     = 9;
  localparam int CELL_W    = 10;
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Bit positions in the first packet byte
  localparam int FLAG_LEFT   = 0;
  localparam int FLAG_RIGHT  = 1;
  localparam int FLAG_SYNC   = 3;
  localparam int FLAG_XSIGN  = 4;
  localparam int FLAG_YSIGN  = 5;
  localparam int FLAG_XOVF   = 6;
  localparam int FLAG_YOVF   = 7;

  localparam logic OP_DATA     = 1'b0;
  localparam logic OP_RECENTER = 1'b1;

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_WHEEL_MODE  = 3'd1,
    REG_SENSITIVITY = 3'd2,
    REG_COLUMNS     = 3'd3,
    REG_ROWS        = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_LEFT       = 3'd1,
    EV_RIGHT      = 3'd2,
    EV_WHEEL_UP   = 3'd3,
    EV_WHEEL_DOWN = 3'd4,
    EV_MOTION     = 3'd5
  } event_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_STEP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    event_code_t        event_code;
    logic [PTR_W-1:0]   pointer_x;
    logic [PTR_W-1:0]   pointer_y;
    logic               left_button;
    logic               right_button;
    logic signed [7:0]  wheel_delta;
  } ptr_t;

  // Move a position by a signed cell count, clamp to the visible size and
  // to the position maximum.
  function automatic logic [POS_WIDTH-1:0] step_pos(
    input logic [POS_WIDTH-1:0]    pos,
    input logic signed [CELL_W-1:0] cells,
    input logic [SIZE_W-1:0]        size
  );
    logic signed [STEP_W-1:0] v;
    logic signed [STEP_W-1:0] top;
    logic signed [STEP_W-1:0] size_top;
    v        = $signed(STEP_W'(pos)) + STEP_W'(cells);
    top      = $signed(STEP_W'(POS_MAX));
    size_top = $signed(STEP_W'(size)) - $signed(STEP_W'(1));
    if (size != '0 && size_top < top) begin
      top = size_top;
    end
    if (v < $signed(STEP_W'(0))) begin
      v = '0;
    end
    if (v > top) begin
      v = top;
    end
    return v[POS_WIDTH-1:0];
  endfunction

  // Middle of an axis, saturated at the position maximum.
  function automatic logic [POS_WIDTH-1:0] center_of(input logic [SIZE_W-1:0] size);
    logic [STEP_W-1:0] c;
    c = STEP_W'(size >> 1);
    if (c > STEP_W'(POS_MAX)) begin
      c = STEP_W'(POS_MAX);
    end
    return c[POS_WIDTH-1:0];
  endfunction

endpackage

### sv/ps2_mouse_packet_to_pointer.sv
// PS/2 mouse packet decoder that drives a cell-based text pointer.
// Depends on ps2mp_pkg (types, register indexes, clamp helpers).
//
// Usage: feed raw mouse bytes (operation 0) or a recenter request
// (operation 1) on the cmd channel. Bytes that do not complete a packet,
// recenters and bytes dropped while disabled are taken without a stall. The
// byte that completes a packet starts a sequencer: a decode step, then a
// single shared restoring divider divides the X and then the Y sum of
// accumulator and motion by the sensitivity, then a step that steps and
// clamps the position and one that loads the result register. A completing
// byte thus holds the cmd channel until the sequencer is idle again, also
// while the previous result waits on ptr_stall. Each completed packet gives
// one result on the ptr channel; the result register lets the next bytes be
// taken while that result waits. Configuration goes through the APB port at
// byte addresses 0 (enable), 4 (wheel_mode), 8 (sensitivity), 12 (columns)
// and 16 (rows); write it only while the block is idle.
module ps2_mouse_packet_to_pointer (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  ps2mp_pkg::cmd_t               cmd,
  // result channel
  output logic                          ptr_valid,
  input  logic                          ptr_stall,
  output ps2mp_pkg::ptr_t               ptr,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ps2mp_pkg::ADDR_W-1:0]  paddr,
  input  logic [ps2mp_pkg::DATA_W-1:0]  pwdata,
  output logic [ps2mp_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic                             enable;
  logic                             wheel_mode;
  logic [7:0]                       sensitivity;
  logic [ps2mp_pkg::SIZE_W-1:0]     columns;
  logic [ps2mp_pkg::SIZE_W-1:0]     rows;
  logic                             cfg_write;
  logic [2:0]                       cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      wheel_mode  <= 1'b0;
      sensitivity <= 8'd4;
      columns     <= ps2mp_pkg::SIZE_W'(80);
      rows        <= ps2mp_pkg::SIZE_W'(25);
    end else if (cfg_write) begin
      case (cfg_index)
        ps2mp_pkg::REG_ENABLE:      enable      <= pwdata[0];
        ps2mp_pkg::REG_WHEEL_MODE:  wheel_mode  <= pwdata[0];
        ps2mp_pkg::REG_SENSITIVITY: sensitivity <= pwdata[7:0];
        ps2mp_pkg::REG_COLUMNS:     columns     <= pwdata[ps2mp_pkg::SIZE_W-1:0];
        ps2mp_pkg::REG_ROWS:        rows        <= pwdata[ps2mp_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      ps2mp_pkg::REG_ENABLE:      prdata = ps2mp_pkg::DATA_W'(enable);
      ps2mp_pkg::REG_WHEEL_MODE:  prdata = ps2mp_pkg::DATA_W'(wheel_mode);
      ps2mp_pkg::REG_SENSITIVITY: prdata = ps2mp_pkg::DATA_W'(sensitivity);
      ps2mp_pkg::REG_COLUMNS:     prdata = ps2mp_pkg::DATA_W'(columns);
      ps2mp_pkg::REG_ROWS:        prdata = ps2mp_pkg::DATA_W'(rows);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  ps2mp_pkg::state_t state;
  ps2mp_pkg::state_t state_next;

  logic cmd_fire;
  logic recenter;
  logic take_byte;
  logic last_byte;
  logic packet_done;
  logic out_free;
  logic out_load;
  logic dividing;
  logic div_last;

  logic [1:0] byte_index;
  logic [1:0] last_index;

  assign cmd_fire    = cmd_valid && !cmd_stall;
  assign recenter    = cmd_fire && cmd.operation == ps2mp_pkg::OP_RECENTER;
  // Resync: while waiting for a first byte, drop bytes without the sync bit.
  assign take_byte   = cmd_fire && cmd.operation == ps2mp_pkg::OP_DATA && enable &&
                       !(byte_index == 2'd0 && !cmd.data_byte[ps2mp_pkg::FLAG_SYNC]);
  assign last_index  = wheel_mode ? 2'd3 : 2'd2;
  // An index past the packet length (mode changed mid-packet) also completes.
  assign last_byte   = byte_index >= last_index;
  assign packet_done = take_byte && last_byte;
  assign out_free    = !ptr_valid || !ptr_stall;

  always_comb begin
    state_next = state;
    case (state)
      ps2mp_pkg::ST_IDLE:   if (packet_done) state_next = ps2mp_pkg::ST_DECODE;
      ps2mp_pkg::ST_DECODE: state_next = ps2mp_pkg::ST_DIV_X;
      ps2mp_pkg::ST_DIV_X:  if (div_last) state_next = ps2mp_pkg::ST_DIV_Y;
      ps2mp_pkg::ST_DIV_Y:  if (div_last) state_next = ps2mp_pkg::ST_STEP;
      ps2mp_pkg::ST_STEP:   state_next = ps2mp_pkg::ST_EMIT;
      ps2mp_pkg::ST_EMIT:   if (out_free) state_next = ps2mp_pkg::ST_IDLE;
      default:              state_next = ps2mp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall = 1'b1;
    dividing  = 1'b0;
    out_load  = 1'b0;
    case (state)
      ps2mp_pkg::ST_IDLE:  cmd_stall = 1'b0;
      ps2mp_pkg::ST_DIV_X: dividing  = 1'b1;
      ps2mp_pkg::ST_DIV_Y: dividing  = 1'b1;
      ps2mp_pkg::ST_EMIT:  out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ps2mp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------
  // Packet assembly
  // ---------------------------------------------------------------------
  logic [7:0] packet_bytes [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 2'd0;
    end else if (take_byte) begin
      byte_index <= last_byte ? 2'd0 : byte_index + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte) begin
      packet_bytes[byte_index] <= cmd.data_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Decode: sign-extend, drop motion on overflow, fold into accumulators
  // ---------------------------------------------------------------------
  logic [7:0]                              flags;
  logic signed [ps2mp_pkg::ACC_W-1:0]      dx;
  logic signed [ps2mp_pkg::ACC_W-1:0]      dy;
  logic signed [ps2mp_pkg::SUM_W-1:0]      sum_x;
  logic signed [ps2mp_pkg::SUM_W-1:0]      sum_y;
  logic signed [ps2mp_pkg::SUM_W-1:0]      abs_x;
  logic signed [ps2mp_pkg::SUM_W-1:0]      abs_y;
  logic signed [ps2mp_pkg::ACC_W-1:0]      accum_horizontal;
  logic signed [ps2mp_pkg::ACC_W-1:0]      accum_vertical;

  assign flags = packet_bytes[0];

  always_comb begin
    dx = $signed({flags[ps2mp_pkg::FLAG_XSIGN], packet_bytes[1]});
    dy = $signed({flags[ps2mp_pkg::FLAG_YSIGN], packet_bytes[2]});
    if (flags[ps2mp_pkg::FLAG_XOVF] || flags[ps2mp_pkg::FLAG_YOVF]) begin
      dx = '0;
      dy = '0;
    end
    // Y is inverted so that down is positive
    sum_x = ps2mp_pkg::SUM_W'(accum_horizontal) + ps2mp_pkg::SUM_W'(dx);
    sum_y = ps2mp_pkg::SUM_W'(accum_vertical) - ps2mp_pkg::SUM_W'(dy);
    abs_x = (sum_x < 0) ? -sum_x : sum_x;
    abs_y = (sum_y < 0) ? -sum_y : sum_y;
  end

  logic                              prev_left_level;
  logic                              prev_right_level;
  logic                              left_level;
  logic                              right_level;
  logic                              left_press;
  logic                              right_press;
  logic signed [7:0]                 wheel;
  logic                              y_neg;
  logic [ps2mp_pkg::MAG_W-1:0]       y_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left_level  <= 1'b0;
      prev_right_level <= 1'b0;
    end else if (state == ps2mp_pkg::ST_DECODE) begin
      prev_left_level  <= flags[ps2mp_pkg::FLAG_LEFT];
      prev_right_level <= flags[ps2mp_pkg::FLAG_RIGHT];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ps2mp_pkg::ST_DECODE) begin
      left_level  <= flags[ps2mp_pkg::FLAG_LEFT];
      right_level <= flags[ps2mp_pkg::FLAG_RIGHT];
      left_press  <= flags[ps2mp_pkg::FLAG_LEFT] && !prev_left_level;
      right_press <= flags[ps2mp_pkg::FLAG_RIGHT] && !prev_right_level;
      wheel       <= wheel_mode ? $signed(packet_bytes[3]) : 8'sd0;
      y_neg       <= sum_y < 0;
      y_mag       <= abs_y[ps2mp_pkg::MAG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Shared restoring divider: magnitude / sensitivity, one bit per cycle
  // ---------------------------------------------------------------------
  logic [7:0]                         sens_eff;
  logic [7:0]                         div_rem;
  logic [ps2mp_pkg::MAG_W-1:0]        div_quo;
  logic [ps2mp_pkg::CNT_W-1:0]        div_cnt;
  logic                               div_neg;
  logic [8:0]                         trial;
  logic [8:0]                         trial_diff;
  logic                               trial_ge;
  logic [7:0]                         rem_step;
  logic [ps2mp_pkg::MAG_W-1:0]        quo_step;
  logic signed [ps2mp_pkg::CELL_W-1:0] q_signed;
  logic signed [ps2mp_pkg::ACC_W-1:0]  r_signed;
  logic signed [ps2mp_pkg::CELL_W-1:0] cells_now;
  logic signed [ps2mp_pkg::ACC_W-1:0]  rem_now;

  // A zero sensitivity acts as one
  assign sens_eff   = (sensitivity == 8'd0) ? 8'd1 : sensitivity;
  assign trial      = {div_rem, div_quo[ps2mp_pkg::MAG_W-1]};
  assign trial_diff = trial - {1'b0, sens_eff};
  assign trial_ge   = trial >= {1'b0, sens_eff};
  assign rem_step   = trial_ge ? trial_diff[7:0] : trial[7:0];
  assign quo_step   = {div_quo[ps2mp_pkg::MAG_W-2:0], trial_ge};
  assign div_last   = div_cnt == ps2mp_pkg::CNT_W'(ps2mp_pkg::DIV_STEPS - 1);

  // Truncating division: quotient and remainder take the dividend's sign
  assign q_signed  = $signed({1'b0, quo_step});
  assign r_signed  = $signed({1'b0, rem_step});
  assign cells_now = div_neg ? -q_signed : q_signed;
  assign rem_now   = div_neg ? -r_signed : r_signed;

  always_ff @(posedge clk) begin
    if (state == ps2mp_pkg::ST_DECODE) begin
      div_rem <= '0;
      div_quo <= abs_x[ps2mp_pkg::MAG_W-1:0];
      div_neg <= sum_x < 0;
      div_cnt <= '0;
    end else if (dividing && div_last && state == ps2mp_pkg::ST_DIV_X) begin
      // hand the unit over to the Y axis
      div_rem <= '0;
      div_quo <= y_mag;
      div_neg <= y_neg;
      div_cnt <= '0;
    end else if (dividing) begin
      div_rem <= rem_step;
      div_quo <= quo_step;
      div_cnt <= div_cnt + ps2mp_pkg::CNT_W'(1);
    end
  end

  logic signed [ps2mp_pkg::CELL_W-1:0] cells_x;
  logic signed [ps2mp_pkg::CELL_W-1:0] cells_y;

  always_ff @(posedge clk) begin
    if (dividing && div_last) begin
      if (state == ps2mp_pkg::ST_DIV_X) begin
        cells_x <= cells_now;
      end else begin
        cells_y <= cells_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum_horizontal <= '0;
      accum_vertical   <= '0;
    end else if (dividing && div_last) begin
      if (state == ps2mp_pkg::ST_DIV_X) begin
        accum_horizontal <= rem_now;
      end else begin
        accum_vertical <= rem_now;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Position update
  // ---------------------------------------------------------------------
  logic [ps2mp_pkg::POS_WIDTH-1:0] pos_x;
  logic [ps2mp_pkg::POS_WIDTH-1:0] pos_y;
  logic                            moved_now;
  logic                            moved;

  assign moved_now = cells_x != '0 || cells_y != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
    end else if (recenter) begin
      pos_x <= ps2mp_pkg::center_of(columns);
      pos_y <= ps2mp_pkg::center_of(rows);
    end else if (state == ps2mp_pkg::ST_STEP && moved_now) begin
      // both axes are clamped whenever either one moves
      pos_x <= ps2mp_pkg::step_pos(pos_x, cells_x, columns);
      pos_y <= ps2mp_pkg::step_pos(pos_y, cells_y, rows);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ps2mp_pkg::ST_STEP) begin
      moved <= moved_now;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: one prioritized event per packet
  // ---------------------------------------------------------------------
  ps2mp_pkg::event_code_t code;

  always_comb begin
    if (left_press) begin
      code = ps2mp_pkg::EV_LEFT;
    end else if (right_press) begin
      code = ps2mp_pkg::EV_RIGHT;
    end else if (wheel < 0) begin
      code = ps2mp_pkg::EV_WHEEL_UP;
    end else if (wheel > 0) begin
      code = ps2mp_pkg::EV_WHEEL_DOWN;
    end else if (moved) begin
      code = ps2mp_pkg::EV_MOTION;
    end else begin
      code = ps2mp_pkg::EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_valid <= 1'b0;
    end else if (out_load) begin
      ptr_valid <= 1'b1;
    end else if (ptr_valid && !ptr_stall) begin
      ptr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ptr.event_code   <= code;
      ptr.pointer_x    <= ps2mp_pkg::PTR_W'(pos_x);
      ptr.pointer_y    <= ps2mp_pkg::PTR_W'(pos_y);
      ptr.left_button  <= left_level;
      ptr.right_button <= right_level;
      ptr.wheel_delta  <= wheel;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(ptr_valid) |-> $past(state) == ps2mp_pkg::ST_EMIT)
    else $error("result loaded outside the emit step");

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    state == ps2mp_pkg::ST_EMIT && ptr_valid && ptr_stall |=>
      state == ps2mp_pkg::ST_EMIT)
    else $error("emit step left while the previous result was pending");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == ps2mp_pkg::ST_DIV_X || state == ps2mp_pkg::ST_DIV_Y |->
      div_cnt <= ps2mp_pkg::CNT_W'(ps2mp_pkg::DIV_STEPS - 1))
    else $error("divider step count out of range");

  a_index_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(ptr_valid) |-> byte_index == 2'd0)
    else $error("result produced with a packet still in assembly");

endmodule
